// ===== rtl/htc_pkg.sv =====
`timescale 1ns / 1ps

package htc_pkg;

    localparam int HEAD_W  = 13;
    localparam int ERR_W   = 14;
    localparam int DIST_W  = 13;
    localparam int SPAN_W  = 12;
    localparam int TOL_W   = 12;
    localparam int LEVEL_W = 8;
    localparam int PROD_W  = LEVEL_W + SPAN_W;
    localparam int DRIVE_W = 9;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int NOW_W   = 32;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WRAP = 5'b00010,
        S_EVAL = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        REASON_RUN     = 2'd0,
        REASON_REACHED = 2'd1,
        REASON_NEAR    = 2'd2,
        REASON_TIMEOUT = 2'd3
    } reason_t;

    typedef enum logic [ADDR_W-1:0] {
        REG_TARGET  = 3'd0,
        REG_TOL     = 3'd1,
        REG_HOLD    = 3'd2,
        REG_TIMEOUT = 3'd3,
        REG_KICK_MS = 3'd4,
        REG_KICK_LV = 3'd5,
        REG_RAMP    = 3'd6,
        REG_FLOOR   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   product;
        logic [SPAN_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [LEVEL_W-1:0]  quotient;
    } div_rsp_t;

endpackage

// ===== rtl/heading_turn_controller_top.sv =====
`timescale 1ns / 1ps
// request path: S_IDLE takes the request, S_WRAP applies whole-circle corrections to the error
// (at most one for 4 fraction bits), then S_EVAL and S_FIN, with S_DIV between them when the
// ramp divide runs (8-step serial divider); one request at a time, next request taken the cycle
// after the result is loaded
// reset: asynchronous active low, registers take their defaults and turn timers clear

module heading_turn_controller_top #(
    parameter int HEADING_FRAC_BITS = 4,
    parameter int TIME_WIDTH        = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [htc_pkg::ADDR_W-1:0]          cfg_addr,
    input  logic [htc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [htc_pkg::HEAD_W-1:0]          heading,
    input  logic [htc_pkg::NOW_W-1:0]           now_ms,
    input  logic [htc_pkg::LEVEL_W-1:0]         base_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [htc_pkg::DRIVE_W-1:0]  left_drive,
    output logic signed [htc_pkg::DRIVE_W-1:0]  right_drive,
    output logic                                done_res,
    output logic [1:0]                          finish_reason
);
    import htc_pkg::*;

    localparam int CW     = 20;
    localparam int HALF_I = 180 << HEADING_FRAC_BITS;
    localparam int FULL_I = 360 << HEADING_FRAC_BITS;
    localparam logic signed [CW-1:0] HALF_C     = CW'(HALF_I);
    localparam logic signed [CW-1:0] NEG_HALF_C = CW'(-HALF_I);
    localparam logic signed [CW-1:0] FULL_C     = CW'(FULL_I);

    state_t state_reg, state_next;

    logic [HEAD_W-1:0]   tgt_reg, tgt_next;
    logic [TOL_W-1:0]    tol_reg, tol_next;
    logic [CFG_W-1:0]    hold_reg, hold_next;
    logic [CFG_W-1:0]    timeout_reg, timeout_next;
    logic [CFG_W-1:0]    kick_ms_reg, kick_ms_next;
    logic [LEVEL_W-1:0]  kick_lv_reg, kick_lv_next;
    logic [SPAN_W-1:0]   ramp_reg, ramp_next;
    logic [LEVEL_W-1:0]  floor_reg, floor_next;

    logic [TIME_WIDTH-1:0] start_time_reg, start_time_next;
    logic                  start_valid_reg, start_valid_next;
    logic [TIME_WIDTH-1:0] near_time_reg, near_time_next;
    logic                  near_valid_reg, near_valid_next;

    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [TIME_WIDTH-1:0]   now_reg, now_next;
    logic [LEVEL_W-1:0]      base_reg, base_next;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    reason_t                 reason_reg, reason_next;
    logic                    pos_reg, pos_next;

    logic                       out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0]  out_left_reg, out_left_next;
    logic signed [DRIVE_W-1:0]  out_right_reg, out_right_next;
    logic                       out_done_reg, out_done_next;
    reason_t                    out_reason_reg, out_reason_next;

    logic signed [CW-1:0]   err_ext;
    logic [ERR_W-1:0]       err_abs;
    logic [DIST_W-1:0]      err_mag;
    logic [TOL_W+2:0]       tol5;
    logic                   reached, in_near, hold_ok, timed_out, in_kick, in_ramp;
    logic [TIME_WIDTH-1:0]  elapsed, near_el;
    logic [DRIVE_W-1:0]     lvl9;

    div_req_t div_req;
    div_rsp_t div_rsp;

    htc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        err_ext   = CW'(err_reg);
        err_abs   = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        err_mag   = err_abs[DIST_W-1:0];
        reached   = err_mag <= {1'b0, tol_reg};
        tol5      = {1'b0, tol_reg, 2'b00} + {3'b000, tol_reg};
        in_near   = {1'b0, err_mag, 1'b0} <= tol5;
        elapsed   = start_valid_reg ? TIME_WIDTH'(now_reg - start_time_reg) : '0;
        near_el   = TIME_WIDTH'(now_reg - near_time_reg);
        hold_ok   = near_el >= TIME_WIDTH'(hold_reg);
        timed_out = elapsed > TIME_WIDTH'(timeout_reg);
        in_kick   = elapsed < TIME_WIDTH'(kick_ms_reg);
        in_ramp   = err_mag < {1'b0, ramp_reg};
        lvl9      = {1'b0, level_reg};
    end

    always_comb
    begin
        state_next       = state_reg;
        tgt_next         = tgt_reg;
        tol_next         = tol_reg;
        hold_next        = hold_reg;
        timeout_next     = timeout_reg;
        kick_ms_next     = kick_ms_reg;
        kick_lv_next     = kick_lv_reg;
        ramp_next        = ramp_reg;
        floor_next       = floor_reg;
        start_time_next  = start_time_reg;
        start_valid_next = start_valid_reg;
        near_time_next   = near_time_reg;
        near_valid_next  = near_valid_reg;
        err_next         = err_reg;
        now_next         = now_reg;
        base_next        = base_reg;
        level_next       = level_reg;
        reason_next      = reason_reg;
        pos_next         = pos_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_left_next    = out_left_reg;
        out_right_next   = out_right_reg;
        out_done_next    = out_done_reg;
        out_reason_next  = out_reason_reg;
        div_req.start    = 1'b0;
        div_req.product  = PROD_W'(base_reg * err_mag[SPAN_W-1:0]);
        div_req.divisor  = ramp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    err_next   = ERR_W'({1'b0, tgt_reg}) - ERR_W'({1'b0, heading});
                    now_next   = now_ms[TIME_WIDTH-1:0];
                    base_next  = base_level;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                // one whole-circle correction per cycle
                priority if (err_ext > HALF_C)
                    err_next = ERR_W'(err_ext - FULL_C);
                else if (err_ext < NEG_HALF_C)
                    err_next = ERR_W'(err_ext + FULL_C);
                else
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                start_valid_next = 1'b1;
                if (!start_valid_reg)
                    start_time_next = now_reg;
                pos_next    = !err_reg[ERR_W-1] && (err_reg != '0);
                reason_next = REASON_RUN;
                level_next  = '0;
                state_next  = S_FIN;
                if (!reached)
                begin
                    if (!in_near)
                        near_valid_next = 1'b0;
                    else if (!near_valid_reg)
                    begin
                        near_time_next  = now_reg;
                        near_valid_next = 1'b1;
                    end
                end
                priority if (reached)
                    reason_next = REASON_REACHED;
                else if (in_near && near_valid_reg && hold_ok)
                    reason_next = REASON_NEAR;
                else if (timed_out)
                    reason_next = REASON_TIMEOUT;
                else if (in_kick)
                    level_next = kick_lv_reg;
                else if (in_ramp)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    level_next = base_reg;
                if (reached || (in_near && near_valid_reg && hold_ok) || timed_out)
                begin
                    start_valid_next = 1'b0;
                    near_valid_next  = 1'b0;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    level_next = (div_rsp.quotient < floor_reg) ? floor_reg : div_rsp.quotient;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_reason_next = reason_reg;
                    if (reason_reg != REASON_RUN)
                    begin
                        out_done_next  = 1'b1;
                        out_left_next  = '0;
                        out_right_next = '0;
                    end
                    else
                    begin
                        out_done_next  = 1'b0;
                        out_left_next  = pos_reg ? lvl9 : DRIVE_W'(-lvl9);
                        out_right_next = pos_reg ? DRIVE_W'(-lvl9) : lvl9;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_TARGET:
                begin
                    tgt_next         = cfg_wdata[HEAD_W-1:0];
                    start_valid_next = 1'b0;
                    near_valid_next  = 1'b0;
                end
                REG_TOL:     tol_next     = cfg_wdata[TOL_W-1:0];
                REG_HOLD:    hold_next    = cfg_wdata;
                REG_TIMEOUT: timeout_next = cfg_wdata;
                REG_KICK_MS: kick_ms_next = cfg_wdata;
                REG_KICK_LV: kick_lv_next = cfg_wdata[LEVEL_W-1:0];
                REG_RAMP:    ramp_next    = cfg_wdata[SPAN_W-1:0];
                REG_FLOOR:   floor_next   = cfg_wdata[LEVEL_W-1:0];
                default:     tgt_next     = tgt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tgt_reg         <= '0;
            tol_reg         <= TOL_W'(48);
            hold_reg        <= CFG_W'(300);
            timeout_reg     <= CFG_W'(5000);
            kick_ms_reg     <= CFG_W'(100);
            kick_lv_reg     <= LEVEL_W'(255);
            ramp_reg        <= SPAN_W'(480);
            floor_reg       <= LEVEL_W'(60);
            start_time_reg  <= '0;
            start_valid_reg <= 1'b0;
            near_time_reg   <= '0;
            near_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tgt_reg         <= tgt_next;
            tol_reg         <= tol_next;
            hold_reg        <= hold_next;
            timeout_reg     <= timeout_next;
            kick_ms_reg     <= kick_ms_next;
            kick_lv_reg     <= kick_lv_next;
            ramp_reg        <= ramp_next;
            floor_reg       <= floor_next;
            start_time_reg  <= start_time_next;
            start_valid_reg <= start_valid_next;
            near_time_reg   <= near_time_next;
            near_valid_reg  <= near_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg        <= err_next;
        now_reg        <= now_next;
        base_reg       <= base_next;
        level_reg      <= level_next;
        reason_reg     <= reason_next;
        pos_reg        <= pos_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
        out_done_reg   <= out_done_next;
        out_reason_reg <= out_reason_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign left_drive    = out_left_reg;
    assign right_drive   = out_right_reg;
    assign done_res      = out_done_reg;
    assign finish_reason = out_reason_reg;

`ifndef SYNTHESIS
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> left_drive == '0 && right_drive == '0)
        else $error("finished request with nonzero drive");

    a_done_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> done_res == (finish_reason != REASON_RUN))
        else $error("done flag and finish reason disagree");

    a_drive_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> left_drive == -right_drive)
        else $error("left and right drive not opposite");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");
`endif

endmodule

// ===== rtl/htc_div.sv =====
`timescale 1ns / 1ps

module htc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  htc_pkg::div_req_t req,
    output htc_pkg::div_rsp_t rsp
);
    import htc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [SPAN_W-1:0]   rem_reg, rem_next;
    logic [SPAN_W-1:0]   dvs_reg, dvs_next;
    logic [LEVEL_W-1:0]  low_reg, low_next;
    logic [LEVEL_W-1:0]  q_reg, q_next;
    logic [SPAN_W:0]     trial;
    logic                ge;

    always_comb
    begin
        trial     = {rem_reg, low_reg[LEVEL_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.product[PROD_W-1:LEVEL_W];
            low_next  = req.product[LEVEL_W-1:0];
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring
            rem_next = ge ? SPAN_W'(trial - {1'b0, dvs_reg}) : SPAN_W'(trial);
            low_next = {low_reg[LEVEL_W-2:0], 1'b0};
            q_next   = {q_reg[LEVEL_W-2:0], ge};
            cnt_next = 3'(cnt_reg + 3'd1);
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule
